[rtl/core/mft_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mft_pkg
// Shared types, codes and constants of the 4x4 float transform unit.
// ---------------------------------------------------------------------------
package mft_pkg;

    localparam int ELEMENT_COUNT = 16;
    localparam int IDX_W         = $clog2(ELEMENT_COUNT);

    localparam logic [31:0] ZERO_BITS     = 32'h0000_0000;
    localparam logic [31:0] ONE_BITS      = 32'h3F80_0000;
    localparam logic [31:0] NEG_ZERO_BITS = 32'h8000_0000;
    localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;
    localparam logic [31:0] QNAN_BITS     = 32'h7FC0_0000;

    // translation row: elements 12 to 14
    localparam logic [IDX_W-1:0] POS_FIRST = IDX_W'(12);
    localparam logic [IDX_W-1:0] POS_LAST  = IDX_W'(14);
    localparam logic [IDX_W-1:0] ELEM_LAST = IDX_W'(ELEMENT_COUNT - 1);

    typedef enum logic [3:0] {
        KIND_LOAD      = 4'd0,
        KIND_ZERO      = 4'd1,
        KIND_IDENTITY  = 4'd2,
        KIND_NEGATE    = 4'd3,
        KIND_TRANSPOSE = 4'd4,
        KIND_ADD       = 4'd5,
        KIND_SUB       = 4'd6,
        KIND_MULTIPLY  = 4'd7,
        KIND_POSITION  = 4'd8,
        KIND_READ      = 4'd9
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_NEG,
        ST_ADDSUB,
        ST_TRANS,
        ST_COPY,
        ST_MUL,
        ST_POS,
        ST_READ
    } state_t;

    typedef enum logic [2:0] {
        ACC_SRC_ZERO,
        ACC_SRC_ONE,
        ACC_SRC_NEG,
        ACC_SRC_ADD,
        ACC_SRC_RES,
        ACC_SRC_POS
    } acc_src_t;

    typedef enum logic {
        RES_SRC_ACC,
        RES_SRC_ADD
    } res_src_t;

    typedef enum logic [1:0] {
        ADD_X_ACC,
        ADD_X_SUM,
        ADD_X_NZERO
    } add_x_t;

    typedef enum logic {
        ADD_Y_OPD,
        ADD_Y_PROD
    } add_y_t;

    // controller to datapath command word
    typedef struct packed {
        logic             cap;
        logic             opd_wr;
        logic             acc_rd_idx;
        logic [IDX_W-1:0] acc_addr;
        logic [IDX_W-1:0] opd_addr;
        logic [IDX_W-1:0] res_addr;
        logic             acc_wr;
        logic [IDX_W-1:0] acc_wr_addr;
        acc_src_t         acc_src;
        logic             res_wr;
        logic [IDX_W-1:0] res_wr_addr;
        res_src_t         res_src;
        add_x_t           add_x;
        add_y_t           add_y;
        logic             add_sub;
        logic             sum_load;
        logic             out_load;
    } dp_cmd_t;

endpackage

[rtl/core/mat4_float_transform_unit.sv]
`timescale 1ns / 1ps
// Multiply works 16 elements x 4 steps through one two-stage multiplier and
// one two-stage adder, then copies the result buffer back to the accumulator.
// A read fetches the element and loads the output word once it is free.
// One item is worked at a time; the next is taken once the sequencer is idle.
// Reset clears the accumulator to +0.0 at once; the operand buffer is not reset.
// ---------------------------------------------------------------------------
// mat4_float_transform_unit
// 4x4 single-precision accumulator matrix with operand buffer and read port.
// ---------------------------------------------------------------------------
module mat4_float_transform_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [3:0]                kind,
    input  logic [mft_pkg::IDX_W-1:0] element_index,
    input  logic [31:0]               element_value,
    input  logic [31:0]               pos_x,
    input  logic [31:0]               pos_y,
    input  logic [31:0]               pos_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [31:0]               read_value,
    output logic [mft_pkg::IDX_W-1:0] read_index
);
    import mft_pkg::*;

    dp_cmd_t cmd;

    mft_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mft_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .element_index (element_index),
        .element_value (element_value),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .read_value    (read_value),
        .read_index    (read_index)
    );

endmodule

[rtl/core/mft_fmul.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mft_fmul
// Two-stage IEEE single multiplier, round to nearest even, subnormals kept.
// ---------------------------------------------------------------------------
module mft_fmul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);
    import mft_pkg::*;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
                n = 6'(47 - i);
        end
        return n;
    endfunction

    // stage 1: classify, significand product, exponent sum
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [9:0]  xa, xb;

    logic [47:0] s1_prod_reg;
    logic [9:0]  s1_esum_reg;
    logic        s1_sign_reg, s1_nan_reg, s1_inf_reg, s1_zero_reg;

    always_comb
    begin
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        ma     = {a[30:23] != '0, a[22:0]};
        mb     = {b[30:23] != '0, b[22:0]};
        xa     = (a[30:23] == '0) ? 10'd1 : {2'b00, a[30:23]};
        xb     = (b[30:23] == '0) ? 10'd1 : {2'b00, b[30:23]};
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= ma * mb;
        s1_esum_reg <= xa + xb;
        s1_sign_reg <= a[31] ^ b[31];
        s1_nan_reg  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        s1_inf_reg  <= a_inf | b_inf;
        s1_zero_reg <= a_zero | b_zero;
    end

    // stage 2: normalize, denormalize if needed, round
    logic [5:0]         lz;
    logic [47:0]        pn;
    logic signed [11:0] er;
    logic signed [11:0] dn;
    logic [5:0]         sh;
    logic [95:0]        wide;
    logic [47:0]        ps;
    logic               g, st, inc, ovf;
    logic [7:0]         ef;
    logic [30:0]        base, rnd;
    logic [31:0]        res;
    logic [31:0]        p_reg;

    always_comb
    begin
        lz   = lzc48(s1_prod_reg);
        pn   = s1_prod_reg << lz;
        er   = $signed({2'b00, s1_esum_reg}) - 12'sd126 - $signed({6'b0, lz});
        dn   = 12'sd1 - er;
        if (er >= 12'sd1)
            sh = '0;
        else if (dn > 12'sd50)
            sh = 6'd50;
        else
            sh = dn[5:0];
        wide = {pn, 48'b0} >> sh;
        ps   = wide[95:48];
        g    = ps[23];
        st   = (|ps[22:0]) | (|wide[47:0]);
        inc  = g & (st | ps[24]);
        ef   = (er >= 12'sd1) ? er[7:0] : 8'd0;
        ovf  = (er >= 12'sd255);
        base = {ef, ps[46:24]};
        rnd  = base + {30'b0, inc};
        if (s1_nan_reg)
            res = QNAN_BITS;
        else if (s1_inf_reg || ovf)
            res = {s1_sign_reg, 8'hFF, 23'b0};
        else if (s1_zero_reg)
            res = {s1_sign_reg, 31'b0};
        else
            res = {s1_sign_reg, rnd};
    end

    always_ff @(posedge clk)
    begin
        p_reg <= res;
    end

    assign p = p_reg;

endmodule

[rtl/core/mft_fadd.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mft_fadd
// Two-stage IEEE single adder/subtractor, round to nearest even.
// ---------------------------------------------------------------------------
module mft_fadd
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        sub,
    output logic [31:0] s
);
    import mft_pkg::*;

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 28; i++)
        begin
            if (v[i])
                n = 5'(27 - i);
        end
        return n;
    endfunction

    // stage 1: classify, order by magnitude, align smaller operand
    logic        bs;
    logic [31:0] bb, x, y;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [7:0]  ex, ey, d;
    logic [4:0]  dc;
    logic [23:0] mx, my;
    logic [53:0] awide;
    logic [26:0] yal;

    logic        s1_nan_reg, s1_inf_reg, s1_inf_sign_reg;
    logic        s1_sign_reg, s1_eff_sub_reg, s1_zsign_reg;
    logic [7:0]  s1_ex_reg;
    logic [26:0] s1_mx_reg, s1_my_reg;

    always_comb
    begin
        bs    = b[31] ^ sub;
        bb    = {bs, b[30:0]};
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        if (a[30:0] >= b[30:0])
        begin
            x = a;
            y = bb;
        end
        else
        begin
            x = bb;
            y = a;
        end
        ex    = (x[30:23] == '0) ? 8'd1 : x[30:23];
        ey    = (y[30:23] == '0) ? 8'd1 : y[30:23];
        mx    = {x[30:23] != '0, x[22:0]};
        my    = {y[30:23] != '0, y[22:0]};
        d     = ex - ey;
        dc    = (d > 8'd27) ? 5'd27 : d[4:0];
        awide = {my, 3'b000, 27'b0} >> dc;
        yal   = awide[53:27] | {26'b0, |awide[26:0]};
    end

    always_ff @(posedge clk)
    begin
        s1_nan_reg      <= a_nan | b_nan | (a_inf & b_inf & (a[31] != bs));
        s1_inf_reg      <= a_inf | b_inf;
        s1_inf_sign_reg <= a_inf ? a[31] : bs;
        s1_sign_reg     <= x[31];
        s1_eff_sub_reg  <= x[31] ^ y[31];
        s1_zsign_reg    <= a[31] & bs;
        s1_ex_reg       <= ex;
        s1_mx_reg       <= {mx, 3'b000};
        s1_my_reg       <= yal;
    end

    // stage 2: add, normalize, round
    logic [27:0]       sum, pn, ps;
    logic [4:0]        lz, sh;
    logic signed [9:0] er, dn;
    logic [55:0]       nwide;
    logic              g, st, inc, ovf;
    logic [7:0]        ef;
    logic [30:0]       base, rnd;
    logic [31:0]       res;
    logic [31:0]       s_reg;

    always_comb
    begin
        if (s1_eff_sub_reg)
            sum = {1'b0, s1_mx_reg} - {1'b0, s1_my_reg};
        else
            sum = {1'b0, s1_mx_reg} + {1'b0, s1_my_reg};
        lz    = lzc28(sum);
        pn    = sum << lz;
        er    = $signed({2'b00, s1_ex_reg}) + 10'sd1 - $signed({5'b0, lz});
        dn    = 10'sd1 - er;
        if (er >= 10'sd1)
            sh = '0;
        else if (dn > 10'sd28)
            sh = 5'd28;
        else
            sh = dn[4:0];
        nwide = {pn, 28'b0} >> sh;
        ps    = nwide[55:28];
        g     = ps[3];
        st    = (|ps[2:0]) | (|nwide[27:0]);
        inc   = g & (st | ps[4]);
        ef    = (er >= 10'sd1) ? er[7:0] : 8'd0;
        ovf   = (er >= 10'sd255);
        base  = {ef, ps[26:4]};
        rnd   = base + {30'b0, inc};
        if (s1_nan_reg)
            res = QNAN_BITS;
        else if (s1_inf_reg)
            res = {s1_inf_sign_reg, 8'hFF, 23'b0};
        else if (sum == '0)
            res = {s1_zsign_reg, 31'b0};
        else if (ovf)
            res = {s1_sign_reg, 8'hFF, 23'b0};
        else
            res = {s1_sign_reg, rnd};
    end

    always_ff @(posedge clk)
    begin
        s_reg <= res;
    end

    assign s = s_reg;

endmodule

[rtl/core/mft_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mft_datapath
// Accumulator, operand and result memories, float units and output word.
// ---------------------------------------------------------------------------
module mft_datapath
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mft_pkg::dp_cmd_t         cmd,
    input  logic [mft_pkg::IDX_W-1:0] element_index,
    input  logic [31:0]              element_value,
    input  logic [31:0]              pos_x,
    input  logic [31:0]              pos_y,
    input  logic [31:0]              pos_z,
    output logic [31:0]              read_value,
    output logic [mft_pkg::IDX_W-1:0] read_index
);
    import mft_pkg::*;

    logic [31:0] acc_mem [ELEMENT_COUNT];
    logic [31:0] opd_mem [ELEMENT_COUNT];
    logic [31:0] res_mem [ELEMENT_COUNT];
    logic [ELEMENT_COUNT-1:0] acc_vld_reg;

    logic [31:0] acc_q_reg, opd_q_reg, res_q_reg;
    logic [31:0] sum_reg;
    logic [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0] read_value_reg;
    logic [IDX_W-1:0] read_index_reg;

    logic [IDX_W-1:0] acc_rd_addr;
    logic [31:0] add_a, add_b, add_res, prod;
    logic [31:0] acc_wdata, res_wdata, pos_word;

    assign acc_rd_addr = cmd.acc_rd_idx ? idx_reg : cmd.acc_addr;

    // float units
    mft_fmul u_fmul
    (
        .clk (clk),
        .a   (acc_q_reg),
        .b   (opd_q_reg),
        .p   (prod)
    );

    mft_fadd u_fadd
    (
        .clk (clk),
        .a   (add_a),
        .b   (add_b),
        .sub (cmd.add_sub),
        .s   (add_res)
    );

    // adder operand and write data selection
    always_comb
    begin
        case (cmd.add_x)
            ADD_X_ACC:   add_a = acc_q_reg;
            ADD_X_SUM:   add_a = sum_reg;
            ADD_X_NZERO: add_a = NEG_ZERO_BITS;
            default:     add_a = NEG_ZERO_BITS;
        endcase
        add_b = (cmd.add_y == ADD_Y_PROD) ? prod : opd_q_reg;

        case (cmd.acc_wr_addr[1:0])
            2'd0:    pos_word = pos_x_reg;
            2'd1:    pos_word = pos_y_reg;
            default: pos_word = pos_z_reg;
        endcase

        case (cmd.acc_src)
            ACC_SRC_ZERO: acc_wdata = ZERO_BITS;
            ACC_SRC_ONE:  acc_wdata = ONE_BITS;
            ACC_SRC_NEG:  acc_wdata = acc_q_reg ^ SIGN_BIT;
            ACC_SRC_ADD:  acc_wdata = add_res;
            ACC_SRC_RES:  acc_wdata = res_q_reg;
            ACC_SRC_POS:  acc_wdata = pos_word;
            default:      acc_wdata = ZERO_BITS;
        endcase
        res_wdata = (cmd.res_src == RES_SRC_ADD) ? add_res : acc_q_reg;
    end

    // accumulator valid bits: unwritten entries read as +0.0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_vld_reg <= '0;
        else if (cmd.acc_wr)
            acc_vld_reg[cmd.acc_wr_addr] <= 1'b1;
    end

    // memories with registered read data
    always_ff @(posedge clk)
    begin
        if (cmd.acc_wr)
            acc_mem[cmd.acc_wr_addr] <= acc_wdata;
        acc_q_reg <= acc_vld_reg[acc_rd_addr] ? acc_mem[acc_rd_addr] : ZERO_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.opd_wr)
            opd_mem[element_index] <= element_value;
        opd_q_reg <= opd_mem[cmd.opd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_wr)
            res_mem[cmd.res_wr_addr] <= res_wdata;
        res_q_reg <= res_mem[cmd.res_addr];
    end

    // item capture, running sum, output word
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            idx_reg   <= element_index;
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            pos_z_reg <= pos_z;
        end
        if (cmd.sum_load)
            sum_reg <= add_res;
        if (cmd.out_load)
        begin
            read_value_reg <= acc_q_reg;
            read_index_reg <= idx_reg;
        end
    end

    assign read_value = read_value_reg;
    assign read_index = read_index_reg;

endmodule

[rtl/core/mft_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mft_ctrl
// Sequencer: walks the elements for each item kind and drives the datapath.
// ---------------------------------------------------------------------------
module mft_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [3:0]             kind,
    output logic                   out_valid,
    input  logic                   out_stall,
    output mft_pkg::dp_cmd_t       cmd
);
    import mft_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] elem_reg, elem_next;
    logic [1:0]       k_reg, k_next;
    logic [2:0]       ph_reg, ph_next;
    logic             ident_reg, ident_next;
    logic             sub_reg, sub_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             last_elem;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign last_elem = (elem_reg == ELEM_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elem_reg      <= '0;
            k_reg         <= '0;
            ph_reg        <= '0;
            ident_reg     <= 1'b0;
            sub_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elem_reg      <= elem_next;
            k_reg         <= k_next;
            ph_reg        <= ph_next;
            ident_reg     <= ident_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        elem_next      = elem_reg;
        k_next         = k_reg;
        ph_next        = ph_reg;
        ident_next     = ident_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.cap   = 1'b1;
                    elem_next = '0;
                    k_next    = '0;
                    ph_next   = '0;
                    unique case (kind)
                        KIND_LOAD:      cmd.opd_wr = 1'b1;
                        KIND_ZERO:
                        begin
                            ident_next = 1'b0;
                            state_next = ST_FILL;
                        end
                        KIND_IDENTITY:
                        begin
                            ident_next = 1'b1;
                            state_next = ST_FILL;
                        end
                        KIND_NEGATE:    state_next = ST_NEG;
                        KIND_TRANSPOSE: state_next = ST_TRANS;
                        KIND_ADD:
                        begin
                            sub_next   = 1'b0;
                            state_next = ST_ADDSUB;
                        end
                        KIND_SUB:
                        begin
                            sub_next   = 1'b1;
                            state_next = ST_ADDSUB;
                        end
                        KIND_MULTIPLY:  state_next = ST_MUL;
                        KIND_POSITION:
                        begin
                            elem_next  = POS_FIRST;
                            state_next = ST_POS;
                        end
                        KIND_READ:      state_next = ST_READ;
                        default:        ;
                    endcase
                end
            end

            // one write per cycle, ones on the diagonal for identity
            ST_FILL:
            begin
                cmd.acc_wr      = 1'b1;
                cmd.acc_wr_addr = elem_reg;
                cmd.acc_src     = (ident_reg && elem_reg[1:0] == elem_reg[3:2]) ?
                                  ACC_SRC_ONE : ACC_SRC_ZERO;
                elem_next       = elem_reg + 1'b1;
                if (last_elem)
                    state_next = ST_IDLE;
            end

            ST_NEG:
            begin
                cmd.acc_addr = elem_reg;
                if (ph_reg == 3'd0)
                    ph_next = 3'd1;
                else
                begin
                    cmd.acc_wr      = 1'b1;
                    cmd.acc_wr_addr = elem_reg;
                    cmd.acc_src     = ACC_SRC_NEG;
                    ph_next         = '0;
                    elem_next       = elem_reg + 1'b1;
                    if (last_elem)
                        state_next = ST_IDLE;
                end
            end

            // read, add in two stages, write back in place
            ST_ADDSUB:
            begin
                cmd.acc_addr = elem_reg;
                cmd.opd_addr = elem_reg;
                cmd.add_x    = ADD_X_ACC;
                cmd.add_y    = ADD_Y_OPD;
                cmd.add_sub  = sub_reg;
                ph_next      = ph_reg + 1'b1;
                if (ph_reg == 3'd3)
                begin
                    cmd.acc_wr      = 1'b1;
                    cmd.acc_wr_addr = elem_reg;
                    cmd.acc_src     = ACC_SRC_ADD;
                    ph_next         = '0;
                    elem_next       = elem_reg + 1'b1;
                    if (last_elem)
                        state_next = ST_IDLE;
                end
            end

            // gather transposed into result buffer, then copy back
            ST_TRANS:
            begin
                cmd.acc_addr = {elem_reg[1:0], elem_reg[3:2]};
                if (ph_reg == 3'd0)
                    ph_next = 3'd1;
                else
                begin
                    cmd.res_wr      = 1'b1;
                    cmd.res_wr_addr = elem_reg;
                    cmd.res_src     = RES_SRC_ACC;
                    ph_next         = '0;
                    elem_next       = elem_reg + 1'b1;
                    if (last_elem)
                        state_next = ST_COPY;
                end
            end

            ST_COPY:
            begin
                cmd.res_addr = elem_reg;
                if (ph_reg == 3'd0)
                    ph_next = 3'd1;
                else
                begin
                    cmd.acc_wr      = 1'b1;
                    cmd.acc_wr_addr = elem_reg;
                    cmd.acc_src     = ACC_SRC_RES;
                    ph_next         = '0;
                    elem_next       = elem_reg + 1'b1;
                    if (last_elem)
                        state_next = ST_IDLE;
                end
            end

            // one product and one add per step, four steps per element
            ST_MUL:
            begin
                cmd.acc_addr = {elem_reg[3:2], k_reg};
                cmd.opd_addr = {k_reg, elem_reg[1:0]};
                cmd.add_x    = (k_reg == 2'd0) ? ADD_X_NZERO : ADD_X_SUM;
                cmd.add_y    = ADD_Y_PROD;
                ph_next      = ph_reg + 1'b1;
                if (ph_reg == 3'd5)
                begin
                    cmd.sum_load    = 1'b1;
                    cmd.res_wr      = (k_reg == 2'd3);
                    cmd.res_wr_addr = elem_reg;
                    cmd.res_src     = RES_SRC_ADD;
                    ph_next         = '0;
                    k_next          = k_reg + 1'b1;
                    if (k_reg == 2'd3)
                    begin
                        elem_next = elem_reg + 1'b1;
                        if (last_elem)
                            state_next = ST_COPY;
                    end
                end
            end

            ST_POS:
            begin
                cmd.acc_wr      = 1'b1;
                cmd.acc_wr_addr = elem_reg;
                cmd.acc_src     = ACC_SRC_POS;
                elem_next       = elem_reg + 1'b1;
                if (elem_reg == POS_LAST)
                    state_next = ST_IDLE;
            end

            // fetch element, hand it over once the output word is free
            ST_READ:
            begin
                cmd.acc_rd_idx = 1'b1;
                if (ph_reg == 3'd0)
                    ph_next = 3'd1;
                else if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    ph_next        = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 float transform unit. The operand buffer is
// loaded early, then directed and random matrix operations run. Every read
// word is checked against a bit-exact software matrix model; float arithmetic
// goes through doubles, with rounding back to single done in integer code.
// ---------------------------------------------------------------------------
module tb_top;
    import mft_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 500;

    typedef struct {
        logic [3:0]       kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      val;
        logic [31:0]      px;
        logic [31:0]      py;
        logic [31:0]      pz;
    } op_word_t;

    typedef struct {
        logic [31:0]      value;
        logic [IDX_W-1:0] index;
    } read_word_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [3:0]       kind;
    logic [IDX_W-1:0] element_index;
    logic [31:0]      element_value;
    logic [31:0]      pos_x;
    logic [31:0]      pos_y;
    logic [31:0]      pos_z;
    logic             out_valid;
    logic             out_stall;
    logic [31:0]      read_value;
    logic [IDX_W-1:0] read_index;

    op_word_t   pending_ops[$];
    read_word_t expected_reads[$];
    logic [31:0] acc_m[ELEMENT_COUNT];
    logic [31:0] opd_m[ELEMENT_COUNT];
    int  mismatches;
    int  in_gap;
    int  out_gap;
    int  idle_cycles;
    bit  quiet;
    bit  stim_done;

    mat4_float_transform_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .element_index(element_index), .element_value(element_value),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_value(read_value), .read_index(read_index)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // single bits to double, exact
    function automatic real sgl_to_dbl(logic [31:0] b);
        logic [63:0] d;
        int          e;
        logic [23:0] m;
        e = b[30:23];
        m = {1'b0, b[22:0]};
        if (e == 255)
            d = {b[31], 11'h7FF, (m != 0) ? 52'h8_0000_0000_0000 : 52'h0};
        else if (e == 0 && m == 0)
            d = {b[31], 63'h0};
        else
        begin
            if (e == 0)
            begin
                // subnormal: normalize
                e = 1;
                while (m[23] == 1'b0)
                begin
                    m = m << 1;
                    e = e - 1;
                end
            end
            d = {b[31], 11'(e - 127 + 1023), m[22:0], 29'h0};
        end
        return $bitstoreal(d);
    endfunction

    // double to single bits, round to nearest even, NaN made canonical
    function automatic logic [31:0] dbl_to_sgl(real r);
        logic [63:0]     d;
        int              e;
        int              sh;
        longint unsigned full;
        longint unsigned kept;
        longint unsigned rem;
        longint unsigned half;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? QNAN_BITS : {d[63], 8'hFF, 23'h0};
        if (d[62:52] == 0)
            return {d[63], 31'h0};
        e    = int'(d[62:52]) - 1023;
        full = {11'h0, 1'b1, d[51:0]};
        if (e > 127)
            return {d[63], 8'hFF, 23'h0};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60)
            return {d[63], 31'h0};
        kept = full >> sh;
        rem  = full & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 1;
        if (e >= -126)
        begin
            if (kept == (64'd1 << 24))
            begin
                kept = kept >> 1;
                e = e + 1;
            end
            if (e > 127)
                return {d[63], 8'hFF, 23'h0};
            return {d[63], 8'(e + 127), kept[22:0]};
        end
        return {d[63], kept[30:0]};
    endfunction

    function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
        return dbl_to_sgl(sgl_to_dbl(a) + sgl_to_dbl(b));
    endfunction

    function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
        return dbl_to_sgl(sgl_to_dbl(a) * sgl_to_dbl(b));
    endfunction

    // apply one accepted word to the matrix model
    task automatic apply_op(op_word_t w);
        logic [31:0] tmp[ELEMENT_COUNT];
        logic [31:0] s;
        read_word_t  rd;
        case (kind_t'(w.kind))
            KIND_LOAD:     opd_m[w.idx] = w.val;
            KIND_ZERO:     foreach (acc_m[i]) acc_m[i] = ZERO_BITS;
            KIND_IDENTITY: foreach (acc_m[i]) acc_m[i] = (i % 5 == 0) ? ONE_BITS : ZERO_BITS;
            KIND_NEGATE:   foreach (acc_m[i]) acc_m[i] = acc_m[i] ^ SIGN_BIT;
            KIND_TRANSPOSE:
            begin
                foreach (tmp[i]) tmp[i] = acc_m[(i % 4) * 4 + i / 4];
                acc_m = tmp;
            end
            KIND_ADD:      foreach (acc_m[i]) acc_m[i] = f_add(acc_m[i], opd_m[i]);
            KIND_SUB:      foreach (acc_m[i]) acc_m[i] = f_add(acc_m[i], opd_m[i] ^ SIGN_BIT);
            KIND_MULTIPLY:
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                    begin
                        s = f_mul(acc_m[r * 4], opd_m[c]);
                        for (int k = 1; k < 4; k++)
                            s = f_add(s, f_mul(acc_m[r * 4 + k], opd_m[k * 4 + c]));
                        tmp[r * 4 + c] = s;
                    end
                acc_m = tmp;
            end
            KIND_POSITION:
            begin
                acc_m[12] = w.px;
                acc_m[13] = w.py;
                acc_m[14] = w.pz;
            end
            KIND_READ:
            begin
                rd.value = acc_m[w.idx];
                rd.index = w.idx;
                expected_reads.push_back(rd);
            end
            default: ;
        endcase
    endtask

    // float pattern: specials, moderate values, or raw bits
    function automatic logic [31:0] rand_float();
        logic [31:0] specials[12] = '{32'h0, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
            32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h7F7F_FFFF, 32'h0000_0001,
            32'h0080_0000, 32'h807F_FFFF, 32'hFFFF_FFFF};
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return specials[$urandom_range(0, 11)];
        if (sel == 1)
            return $urandom;
        return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
    endfunction

    function automatic op_word_t make_op(logic [3:0] k, logic [IDX_W-1:0] i,
                                         logic [31:0] v);
        op_word_t w;
        w.kind = k;
        w.idx  = i;
        w.val  = v;
        w.px   = rand_float();
        w.py   = rand_float();
        w.pz   = $urandom;
        return w;
    endfunction

    function automatic op_word_t rand_op();
        int          p;
        logic [3:0]  k;
        p = $urandom_range(0, 99);
        if (p < 30)      k = KIND_LOAD;
        else if (p < 60) k = KIND_READ;
        else if (p < 64) k = 4'($urandom_range(10, 15));
        else             k = 4'($urandom_range(1, 8));
        return make_op(k, IDX_W'($urandom), rand_float());
    endfunction

    // stimulus
    initial
    begin
        foreach (acc_m[i])
        begin
            acc_m[i] = ZERO_BITS;
            opd_m[i] = ZERO_BITS;
        end
        mismatches = 0;
        stim_done  = 1'b0;
        pending_ops.push_back(make_op(KIND_READ, ELEM_LAST, 32'h0));
        for (int i = 0; i < ELEMENT_COUNT; i++)
            pending_ops.push_back(make_op(KIND_LOAD, IDX_W'(i),
                (i == 0) ? 32'hFFFF_FFFF : (i == 15) ? 32'h0 : rand_float()));
        pending_ops.push_back(make_op(KIND_IDENTITY, 0, 0));
        pending_ops.push_back(make_op(KIND_POSITION, 0, 0));
        pending_ops.push_back(make_op(KIND_NEGATE, 0, 0));
        pending_ops.push_back(make_op(KIND_TRANSPOSE, 0, 0));
        pending_ops.push_back(make_op(KIND_ADD, 0, 0));
        pending_ops.push_back(make_op(KIND_SUB, 0, 0));
        pending_ops.push_back(make_op(KIND_MULTIPLY, 0, 0));
        pending_ops.push_back(make_op(4'hF, 0, 0));
        pending_ops.push_back(make_op(KIND_READ, 0, 0));
        pending_ops.push_back(make_op(KIND_ZERO, 0, 0));
        pending_ops.push_back(make_op(KIND_READ, 4'd5, 0));
        for (int n = 0; n < 1100; n++)
            pending_ops.push_back(rand_op());
        // full matrix dump at the end
        for (int i = 0; i < ELEMENT_COUNT; i++)
            pending_ops.push_back(make_op(KIND_READ, IDX_W'(i), 0));

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_ops.size() == 0 && !in_valid && expected_reads.size() == 0);
        stim_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_reads.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        op_word_t w;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            kind          <= 4'h0;
            element_index <= '0;
            element_value <= 32'h0;
            pos_x         <= 32'h0;
            pos_y         <= 32'h0;
            pos_z         <= 32'h0;
            in_gap        = 0;
            quiet         = 1'b0;
        end
        else
        begin
            quiet = (pending_ops.size() < 150);
            if (in_valid && !in_stall)
                apply_op('{kind, element_index, element_value, pos_x, pos_y, pos_z});
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    w = pending_ops.pop_front();
                    in_valid      <= 1'b1;
                    kind          <= w.kind;
                    element_index <= w.idx;
                    element_value <= w.val;
                    pos_x         <= w.px;
                    pos_y         <= w.py;
                    pos_z         <= w.pz;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 12);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor with random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        read_word_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reads.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected read word: value %h index %0d",
                                 read_value, read_index);
                end
                else
                begin
                    e = expected_reads.pop_front();
                    if (read_value !== e.value || read_index !== e.index)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("read mismatch: exp %h @%0d, got %h @%0d",
                                     e.value, e.index, read_value, read_index);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: cycles with no word accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || stim_done || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

[mat4_float_transform_unit.f]
rtl/core/mft_pkg.sv
rtl/core/mft_fmul.sv
rtl/core/mft_fadd.sv
rtl/core/mft_datapath.sv
rtl/core/mft_ctrl.sv
rtl/core/mat4_float_transform_unit.sv
sim/tb_top.sv
